### hw/rtl/dual_motor_pwm_random_walk_unit_assert.svh
// Assertion macros for the dual-motor PWM unit.
// Used by files that include this header; expects clk and rst_n in scope.
`ifndef DUAL_MOTOR_PWM_RANDOM_WALK_UNIT_ASSERT_SVH
`define DUAL_MOTOR_PWM_RANDOM_WALK_UNIT_ASSERT_SVH

// checked only out of reset
`define DMPW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DMPW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/dmpw_pkg.sv
// Package for the dual-motor PWM unit: item types, register set, codes.
// No dependencies.
package dmpw_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_PATTERN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKWARD_PATTERN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MOTOR_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MOTOR_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WANDER_EN          = 3'd4;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam logic [1:0] MODE_FWD   = 2'd0;
    localparam logic [1:0] MODE_BACK  = 2'd1;
    localparam logic [1:0] MODE_LEFT  = 2'd2;
    localparam logic [1:0] MODE_RIGHT = 2'd3;

    localparam logic [7:0] DUTY_FAST   = 8'd4;
    localparam logic [7:0] DUTY_SLOW   = 8'd2;
    localparam logic [7:0] DUTY_WANDER = 8'd2;

    localparam logic [7:0] PERIOD_NORMAL = 8'd5;
    localparam logic [7:0] PERIOD_TURN   = 8'd8;

    // (x * 205) >> 11 is x / 10 for any 10-bit x
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    typedef struct packed {
        logic        op;
        logic [1:0]  cmd_mode;
        logic [7:0]  cmd_left_duty;
        logic [7:0]  cmd_right_duty;
        logic [15:0] rand_first;
        logic [15:0] rand_second;
        logic        has_food;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pin_drive;
        logic       slow_tick;
        logic [1:0] current_mode;
    } out_item_t;

    typedef struct packed {
        logic [7:0] forward_pattern;
        logic [7:0] backward_pattern;
        logic [7:0] right_motor_mask;
        logic [7:0] left_motor_mask;
        logic       wander_en;
    } cfg_t;

endpackage

### hw/rtl/dmpw_core.sv
// Motor state and per-item update: prescaler, random walk, PWM pattern.
// Depends on dmpw_pkg and the assertion macro header.
`include "dual_motor_pwm_random_walk_unit_assert.svh"

module dmpw_core
    import dmpw_pkg::*;
#(
    parameter int unsigned PRESCALE_TICKS = 100
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      advance,
    input  in_item_t  item,
    output out_item_t result
);

    localparam int PC_W = $clog2(PRESCALE_TICKS + 1);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [7:0]      wc_reg, wc_next;
    logic [7:0]      wt_reg, wt_next;
    logic [7:0]      phase_reg, phase_next;
    logic [1:0]      mode_reg, mode_next;
    logic [7:0]      ld_reg, ld_next;
    logic [7:0]      rd_reg, rd_next;
    logic [7:0]      drive_reg, drive_next;

    logic        slow;
    logic        walk_change;
    logic [9:0]  pick_src;
    logic [17:0] div_prod;
    logic [6:0]  quot;
    logic [9:0]  quot_x10;
    logic [9:0]  rem_full;
    logic [3:0]  pick;
    logic [1:0]  walk_mode;
    logic [1:0]  tick_mode;
    logic [7:0]  ld_walk, rd_walk;
    logic [7:0]  ld_eff, rd_eff;
    logic [7:0]  period;
    logic [7:0]  conf;
    logic        set_bits;
    logic [7:0]  phase_inc;
    logic        tick_adv;
    logic        cmd_adv;
    logic        walk_applied;

    // remainder of (rand_first >> 6) by ten
    always_comb
    begin
        pick_src = item.rand_first[15:6];
        div_prod = 18'(pick_src) * 18'(DIV10_MUL);
        quot     = div_prod[DIV10_SHIFT +: 7];
        quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
        rem_full = pick_src - quot_x10;
        pick     = rem_full[3:0];
    end

    always_comb
    begin
        priority if (pick <= 4'd1)
            walk_mode = MODE_LEFT;
        else if (pick <= 4'd3)
            walk_mode = MODE_RIGHT;
        else if (pick == 4'd4)
            walk_mode = item.has_food ? MODE_FWD : MODE_BACK;
        else
            walk_mode = MODE_FWD;
    end

    always_comb
    begin
        slow        = (pc_reg == PC_W'(PRESCALE_TICKS));
        walk_change = slow && cfg.wander_en && (wc_reg == wt_reg);
        tick_mode   = walk_change ? walk_mode : mode_reg;
        ld_walk     = walk_change ? DUTY_WANDER : ld_reg;
        rd_walk     = walk_change ? DUTY_WANDER : rd_reg;

        unique case (tick_mode)
            MODE_FWD:
            begin
                period   = PERIOD_NORMAL;
                conf     = cfg.forward_pattern;
                set_bits = 1'b0;
                ld_eff   = ld_walk;
                rd_eff   = rd_walk;
            end
            MODE_BACK:
            begin
                period   = PERIOD_NORMAL;
                conf     = cfg.backward_pattern;
                set_bits = 1'b1;
                ld_eff   = ld_walk;
                rd_eff   = rd_walk;
            end
            MODE_LEFT:
            begin
                period   = PERIOD_TURN;
                conf     = cfg.forward_pattern;
                set_bits = 1'b1;
                ld_eff   = DUTY_SLOW;
                rd_eff   = DUTY_FAST;
            end
            default:
            begin
                period   = PERIOD_NORMAL;
                conf     = cfg.forward_pattern;
                set_bits = 1'b1;
                ld_eff   = DUTY_FAST;
                rd_eff   = DUTY_SLOW;
            end
        endcase

        // right mask first, then left
        if (phase_reg >= rd_eff)
            conf = set_bits ? (conf | cfg.right_motor_mask) : (conf & ~cfg.right_motor_mask);
        if (phase_reg >= ld_eff)
            conf = set_bits ? (conf | cfg.left_motor_mask) : (conf & ~cfg.left_motor_mask);

        phase_inc = phase_reg + 8'd1;
    end

    always_comb
    begin
        pc_next    = pc_reg;
        wc_next    = wc_reg;
        wt_next    = wt_reg;
        phase_next = phase_reg;
        mode_next  = mode_reg;
        ld_next    = ld_reg;
        rd_next    = rd_reg;
        drive_next = drive_reg;
        result     = '{pin_drive: drive_reg, slow_tick: 1'b0, current_mode: mode_reg};

        if (item.op == OP_COMMAND)
        begin
            mode_next = item.cmd_mode;
            ld_next   = item.cmd_left_duty;
            rd_next   = item.cmd_right_duty;
            result    = '{pin_drive: drive_reg, slow_tick: 1'b0,
                          current_mode: item.cmd_mode};
        end
        else
        begin
            pc_next = slow ? PC_W'(1) : pc_reg + PC_W'(1);
            if (walk_change)
            begin
                wc_next = 8'd1;
                wt_next = item.rand_second[12:5] + 8'd1;
            end
            else if (slow && cfg.wander_en)
                wc_next = wc_reg + 8'd1;
            mode_next  = tick_mode;
            ld_next    = ld_eff;
            rd_next    = rd_eff;
            drive_next = conf;
            phase_next = (phase_inc == period) ? 8'd0 : phase_inc;
            result     = '{pin_drive: conf, slow_tick: slow, current_mode: tick_mode};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            wc_reg    <= '0;
            wt_reg    <= '0;
            phase_reg <= '0;
            mode_reg  <= MODE_FWD;
            ld_reg    <= '0;
            rd_reg    <= '0;
            drive_reg <= '0;
        end
        else if (advance)
        begin
            pc_reg    <= pc_next;
            wc_reg    <= wc_next;
            wt_reg    <= wt_next;
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            ld_reg    <= ld_next;
            rd_reg    <= rd_next;
            drive_reg <= drive_next;
        end
    end

    assign tick_adv     = advance && (item.op == OP_TICK);
    assign cmd_adv      = advance && (item.op == OP_COMMAND);
    assign walk_applied = (wc_reg == 8'd1) && ((ld_reg == DUTY_WANDER) ||
                          (mode_reg == MODE_LEFT) || (mode_reg == MODE_RIGHT));

    `DMPW_ASSERT_ALWAYS(a_pc_bounded, pc_reg <= PC_W'(PRESCALE_TICKS), "prescaler overran")
    `DMPW_ASSERT(a_slow_restarts_pc, tick_adv && slow |=> pc_reg == PC_W'(1), "prescaler not restarted")
    `DMPW_ASSERT(a_walk_restarts, tick_adv && walk_change |=> walk_applied, "walk change not applied")
    `DMPW_ASSERT(a_cmd_holds_pc, cmd_adv |=> $stable(pc_reg) && $stable(phase_reg), "command moved a counter")
    `DMPW_ASSERT(a_cmd_holds_drive, cmd_adv |=> $stable(drive_reg), "command moved the drive")

endmodule

### hw/rtl/dual_motor_pwm_random_walk_unit.sv
// Top level of the dual-motor PWM unit: handshakes, register set, item pipeline.
// Depends on dmpw_pkg and dmpw_core.

// Each input item (timer tick or motion command) yields one result item.
// One item is taken per clock while in_ready is high. Its result item passes through
// the input register, then the result register. The input register passes its item
// on only while the result register is empty or being taken, so the block keeps
// taking items until both stages are full. The slow pulse comes every PRESCALE_TICKS
// ticks, the first on tick PRESCALE_TICKS+1.
// Registers are written through the cfg port (always ready) and should only be
// changed while no item is in flight.
module dual_motor_pwm_random_walk_unit
    import dmpw_pkg::*;
#(
    parameter int unsigned PRESCALE_TICKS = 100
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t      cfg_reg;
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t result;
    logic      advance;
    logic      in_take;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FORWARD_PATTERN:    cfg_reg.forward_pattern    <= cfg_data;
                CFG_BACKWARD_PATTERN:   cfg_reg.backward_pattern   <= cfg_data;
                CFG_RIGHT_MOTOR_MASK:   cfg_reg.right_motor_mask   <= cfg_data;
                CFG_LEFT_MOTOR_MASK:    cfg_reg.left_motor_mask    <= cfg_data;
                CFG_WANDER_EN:          cfg_reg.wander_en          <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_take || (s1_valid_reg && !advance);
            out_valid_reg <= advance || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_item;
        if (advance)
            out_item_reg <= result;
    end

    dmpw_core #(
        .PRESCALE_TICKS (PRESCALE_TICKS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .advance (advance),
        .item    (s1_item_reg),
        .result  (result)
    );

endmodule
